// ===== hdl/bfha_pkg.sv =====
// Shared types and codes for the best-fit heap allocator.
// Request and response beats, status and request codes, sequencer states.
// No dependencies.
package bfha_pkg;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_INIT   = 2'd2,
    REQ_UNUSED = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_ADDR = 2'd3
  } status_code_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] req_size;
    logic [15:0] req_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] payload_addr;
  } rsp_t;

  // Flags from the shared segment unit to the sequencer
  typedef struct packed {
    logic merge;
    logic take;
    logic exact;
    logic split_ok;
    logic addr_hit;
  } bfha_flags_t;

  typedef enum logic [3:0] {
    S_BOOT,
    S_IDLE,
    S_M_RD,
    S_M_PROC,
    S_M_LAST,
    S_DECIDE,
    S_SH_RD,
    S_SH_WR,
    S_SPLIT_A,
    S_SPLIT_B,
    S_F_RD,
    S_F_PROC,
    S_DONE
  } state_t;

endpackage

// ===== hdl/bfha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the segment table. No dependencies.
module bfha_ram #(
  parameter int W = 33,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [$clog2(D)-1:0] wr_addr,
  input  logic [W-1:0]         wr_data,
  input  logic                 rd_en,
  input  logic [$clog2(D)-1:0] rd_addr,
  output logic [W-1:0]         rd_data
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/bfha_alu.sv =====
// Shared segment arithmetic: merge sum, fit compares, split sums, address match.
// Depends on bfha_pkg.
module bfha_alu import bfha_pkg::*; #(
  parameter int ADDR_BITS    = 16,
  parameter int HEADER_BYTES = 24
) (
  input  logic [15:0]          size,
  input  logic [15:0]          addr,
  input  logic                 found,
  input  logic [ADDR_BITS-1:0] cur_len,
  input  logic                 cur_free,
  input  logic [ADDR_BITS-1:0] e_off,
  input  logic [ADDR_BITS-1:0] e_len,
  input  logic                 e_free,
  input  logic [ADDR_BITS-1:0] best_off,
  input  logic [ADDR_BITS-1:0] best_len,
  output bfha_flags_t          flags,
  output logic [ADDR_BITS-1:0] merged_len,
  output logic [ADDR_BITS-1:0] new_off,
  output logic [ADDR_BITS-1:0] new_len,
  output logic [ADDR_BITS-1:0] size_len,
  output logic [15:0]          pay_addr
);

  localparam int SW = ((ADDR_BITS > 16) ? ADDR_BITS : 16) + 2;

  logic [SW-1:0] hdr_w, size_w, addr_w, cur_w, e_w, eoff_w, boff_w, best_w;
  logic [SW-1:0] hit_w;

  always_comb begin
    hdr_w  = SW'(HEADER_BYTES);
    size_w = {{(SW-16){1'b0}}, size};
    addr_w = {{(SW-16){1'b0}}, addr};
    cur_w  = {{(SW-ADDR_BITS){1'b0}}, cur_len};
    e_w    = {{(SW-ADDR_BITS){1'b0}}, e_len};
    eoff_w = {{(SW-ADDR_BITS){1'b0}}, e_off};
    boff_w = {{(SW-ADDR_BITS){1'b0}}, best_off};
    best_w = {{(SW-ADDR_BITS){1'b0}}, best_len};

    merged_len = ADDR_BITS'(cur_w + e_w + hdr_w);
    new_off    = ADDR_BITS'(boff_w + hdr_w + size_w);
    new_len    = ADDR_BITS'(best_w - size_w - hdr_w);
    size_len   = ADDR_BITS'(size_w);
    pay_addr   = 16'(boff_w + hdr_w);
    hit_w      = {{(SW-ADDR_BITS){1'b0}}, ADDR_BITS'(eoff_w + hdr_w)};

    flags.merge    = cur_free && e_free;
    flags.take     = cur_free && (cur_w >= size_w) && (!found || (cur_w < best_w));
    flags.exact    = (best_w == size_w);
    flags.split_ok = (best_w > (size_w + hdr_w));
    flags.addr_hit = (hit_w == addr_w);
  end

endmodule

// ===== hdl/best_fit_heap_allocator_unit.sv =====
// Top level of the best-fit heap allocator with segment coalescing.
// Depends on bfha_pkg, bfha_ram (segment table) and bfha_alu (shared unit).
//
// Usage:
//  - Request channel in_valid/in_ready/in_req carries one beat per request:
//    allocate, free or reinitialize. Response channel out_valid/out_ready/
//    out_rsp returns exactly one beat per request, in order.
//  - Config channel cfg_valid/cfg_ready/cfg_data writes arena_bytes; it is
//    ready whenever reset is released and takes effect at the next
//    reinitialize request.
//  - One request is worked at a time; in_ready is low while it runs.
//    Allocate: a merge/best-fit pass over every table entry, then for a
//    split a shift of each entry above the chosen one. Free: a scan of
//    entries until the match. Reinitialize: one table write, then the
//    response. The single RAM read port, read once per entry, sets the pace.
//  - Reset clears the sequencer and runs the boot write of the initial
//    free segment before in_ready rises.
//  - A finished response sits in the output register; the next request is
//    accepted while it waits, but its own response holds until out_ready.
module best_fit_heap_allocator_unit import bfha_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int HEADER_BYTES = 24,
  parameter int ADDR_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_req,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = 2 * ADDR_BITS + 1;
  localparam int SW = ((ADDR_BITS > 16) ? ADDR_BITS : 16) + 1;
  localparam logic [15:0] ARENA_RESET = 16'd8192;

  state_t state_r, state_nxt;
  req_t   req_r, req_nxt;
  rsp_t   rsp_r, rsp_nxt, out_rsp_r, out_rsp_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [15:0] arena_r;
  logic [CW-1:0] cnt_r, cnt_nxt, sh_r, sh_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt, w_r, w_nxt, best_idx_r, best_idx_nxt;
  logic [ADDR_BITS-1:0] cur_off_r, cur_off_nxt, cur_len_r, cur_len_nxt;
  logic [ADDR_BITS-1:0] best_off_r, best_off_nxt, best_len_r, best_len_nxt;
  logic cur_free_r, cur_free_nxt, found_r, found_nxt, first_r, first_nxt;

  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data, rd_data;
  logic [ADDR_BITS-1:0] e_off, e_len;
  logic                 e_free;

  bfha_flags_t          flags;
  logic [ADDR_BITS-1:0] merged_len, new_off, new_len, size_len, init_len;
  logic [15:0]          pay_addr;
  logic [SW-1:0]        arena_w;
  logic                 last_rd;

  bfha_ram #(.W(EW), .D(MAX_SEGMENTS)) u_table (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_en, .rd_addr, .rd_data
  );

  bfha_alu #(.ADDR_BITS(ADDR_BITS), .HEADER_BYTES(HEADER_BYTES)) u_alu (
    .size(req_r.req_size), .addr(req_r.req_addr), .found(found_r),
    .cur_len(cur_len_r), .cur_free(cur_free_r),
    .e_off, .e_len, .e_free,
    .best_off(best_off_r), .best_len(best_len_r),
    .flags, .merged_len, .new_off, .new_len, .size_len, .pay_addr
  );

  assign e_off  = rd_data[EW-1 -: ADDR_BITS];
  assign e_len  = rd_data[ADDR_BITS:1];
  assign e_free = rd_data[0];

  // Length of the single free segment that a rebuild creates
  assign arena_w  = {{(SW-16){1'b0}}, arena_r};
  assign init_len = (arena_w > SW'(HEADER_BYTES)) ?
                    ADDR_BITS'(arena_w - SW'(HEADER_BYTES)) : '0;
  assign last_rd  = ((CW'(rd_idx_r) + CW'(1)) == cnt_r);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = rst_n;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BOOT;
      out_valid_r <= 1'b0;
      arena_r     <= ARENA_RESET;
      cnt_r       <= CW'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_valid) begin
        arena_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    rsp_r      <= rsp_nxt;
    out_rsp_r  <= out_rsp_nxt;
    sh_r       <= sh_nxt;
    rd_idx_r   <= rd_idx_nxt;
    w_r        <= w_nxt;
    best_idx_r <= best_idx_nxt;
    cur_off_r  <= cur_off_nxt;
    cur_len_r  <= cur_len_nxt;
    cur_free_r <= cur_free_nxt;
    best_off_r <= best_off_nxt;
    best_len_r <= best_len_nxt;
    found_r    <= found_nxt;
    first_r    <= first_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    rsp_nxt       = rsp_r;
    out_rsp_nxt   = out_rsp_r;
    out_valid_nxt = out_valid_r;
    cnt_nxt       = cnt_r;
    sh_nxt        = sh_r;
    rd_idx_nxt    = rd_idx_r;
    w_nxt         = w_r;
    best_idx_nxt  = best_idx_r;
    cur_off_nxt   = cur_off_r;
    cur_len_nxt   = cur_len_r;
    cur_free_nxt  = cur_free_r;
    best_off_nxt  = best_off_r;
    best_len_nxt  = best_len_r;
    found_nxt     = found_r;
    first_nxt     = first_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = rd_idx_r;

    // Drop the response once the receiver takes it
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_BOOT: begin
        wr_en     = 1'b1;
        wr_data   = {{ADDR_BITS{1'b0}}, init_len, 1'b1};
        cnt_nxt   = CW'(1);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_req;
          rsp_nxt    = '0;
          rd_idx_nxt = '0;
          w_nxt      = '0;
          found_nxt  = 1'b0;
          first_nxt  = 1'b1;
          case (req_code_t'(in_req.req_type))
            REQ_ALLOC: state_nxt = S_M_RD;
            REQ_FREE:  state_nxt = S_F_RD;
            REQ_INIT:  state_nxt = S_BOOT;
            default:   state_nxt = S_DONE;
          endcase
          // Rebuild does the boot write here and goes straight to the finish
          // step, so that it returns a response
          if (req_code_t'(in_req.req_type) == REQ_INIT) begin
            state_nxt = S_DONE;
            wr_en     = 1'b1;
            wr_data   = {{ADDR_BITS{1'b0}}, init_len, 1'b1};
            cnt_nxt   = CW'(1);
          end
        end
      end
      // Merge pass fused with best-fit search: the pending segment is held
      // in cur_*, finished segments are written back compacted at w_r
      S_M_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_M_PROC;
      end
      S_M_PROC: begin
        if (first_r) begin
          first_nxt    = 1'b0;
          cur_off_nxt  = e_off;
          cur_len_nxt  = e_len;
          cur_free_nxt = e_free;
        end else if (flags.merge) begin
          cur_len_nxt = merged_len;
        end else begin
          wr_en   = 1'b1;
          wr_addr = w_r;
          wr_data = {cur_off_r, cur_len_r, cur_free_r};
          if (flags.take) begin
            found_nxt    = 1'b1;
            best_idx_nxt = w_r;
            best_off_nxt = cur_off_r;
            best_len_nxt = cur_len_r;
          end
          w_nxt        = w_r + IW'(1);
          cur_off_nxt  = e_off;
          cur_len_nxt  = e_len;
          cur_free_nxt = e_free;
        end
        rd_idx_nxt = rd_idx_r + IW'(1);
        state_nxt  = last_rd ? S_M_LAST : S_M_RD;
      end
      S_M_LAST: begin
        wr_en   = 1'b1;
        wr_addr = w_r;
        wr_data = {cur_off_r, cur_len_r, cur_free_r};
        if (flags.take) begin
          found_nxt    = 1'b1;
          best_idx_nxt = w_r;
          best_off_nxt = cur_off_r;
          best_len_nxt = cur_len_r;
        end
        cnt_nxt   = CW'(w_r) + CW'(1);
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        if (!found_r) begin
          rsp_nxt.status = ST_NO_FIT;
        end else if (flags.exact) begin
          wr_en   = 1'b1;
          wr_addr = best_idx_r;
          wr_data = {best_off_r, best_len_r, 1'b0};
          rsp_nxt.payload_addr = pay_addr;
        end else if (flags.split_ok) begin
          if (cnt_r == CW'(MAX_SEGMENTS)) begin
            rsp_nxt.status = ST_FULL;
          end else begin
            sh_nxt    = cnt_r;
            state_nxt = S_SH_RD;
          end
        end else begin
          rsp_nxt.status = ST_NO_FIT;
        end
      end
      // Open a slot after the chosen segment, moving entries up one by one
      S_SH_RD: begin
        if (sh_r == (CW'(best_idx_r) + CW'(1))) begin
          state_nxt = S_SPLIT_A;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = IW'(sh_r - CW'(1));
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        wr_en     = 1'b1;
        wr_addr   = IW'(sh_r);
        wr_data   = rd_data;
        sh_nxt    = sh_r - CW'(1);
        state_nxt = S_SH_RD;
      end
      S_SPLIT_A: begin
        wr_en     = 1'b1;
        wr_addr   = best_idx_r + IW'(1);
        wr_data   = {new_off, new_len, 1'b1};
        state_nxt = S_SPLIT_B;
      end
      S_SPLIT_B: begin
        wr_en   = 1'b1;
        wr_addr = best_idx_r;
        wr_data = {best_off_r, size_len, 1'b0};
        cnt_nxt = cnt_r + CW'(1);
        rsp_nxt.payload_addr = pay_addr;
        state_nxt = S_DONE;
      end
      S_F_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_F_PROC;
      end
      S_F_PROC: begin
        if (flags.addr_hit) begin
          wr_en     = 1'b1;
          wr_addr   = rd_idx_r;
          wr_data   = {e_off, e_len, 1'b1};
          state_nxt = S_DONE;
        end else if (last_rd) begin
          rsp_nxt.status = ST_BAD_ADDR;
          state_nxt      = S_DONE;
        end else begin
          rd_idx_nxt = rd_idx_r + IW'(1);
          state_nxt  = S_F_RD;
        end
      end
      S_DONE: begin
        // Hold the response until the output register is free
        if (!out_valid_r || out_ready) begin
          out_rsp_nxt   = rsp_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // An exact fit found in the decide step returns OK status
    if (state_r == S_DECIDE && found_r && flags.exact) begin
      rsp_nxt.status = ST_OK;
    end
  end

  // Table occupancy stays within one and the table depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r <= CW'(MAX_SEGMENTS)))
    else $error("segment count out of range");

  // An accepted request keeps the block busy on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  // A response is only loaded from the finish step
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == S_DONE))
    else $error("response loaded outside finish step");

endmodule

// ===== tb/best_fit_heap_allocator_unit_test.sv =====
// Testbench for best_fit_heap_allocator_unit: random and directed requests checked
// against an in-bench segment-table predictor of the allocator.
// Depends on bfha_pkg and the allocator RTL.
`timescale 1ns / 1ps

module best_fit_heap_allocator_unit_test;
  import bfha_pkg::*;

  localparam int MAX_SEGS = 64;
  localparam int HDR      = 24;
  localparam int LIMIT    = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  req_t        in_req;
  logic        out_valid;
  logic        out_ready;
  rsp_t        out_rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  best_fit_heap_allocator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state: shadow of the segment table and the arena register
  logic [15:0] arena_reg;
  logic [15:0] sh_off [MAX_SEGS];
  logic [15:0] sh_len [MAX_SEGS];
  logic        sh_free[MAX_SEGS];
  int          sh_count;

  rsp_t        rsp_pending[$];
  int          err_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run-length guard against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: stall at random, compare each response beat with the oldest prediction
  always @(negedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst_n && out_valid && out_ready) begin
      if (rsp_pending.size() == 0) begin
        $error("response beat with no prediction waiting: status %0d addr %0d",
               out_rsp.status, out_rsp.payload_addr);
        err_count++;
      end else begin
        exp_rsp = rsp_pending.pop_front();
        if (out_rsp.status !== exp_rsp.status) begin
          $error("status: expected %0d actual %0d", exp_rsp.status, out_rsp.status);
          err_count++;
        end
        if (out_rsp.payload_addr !== exp_rsp.payload_addr) begin
          $error("payload_addr: expected %0d actual %0d",
                 exp_rsp.payload_addr, out_rsp.payload_addr);
          err_count++;
        end
      end
    end
  end

  function automatic void rebuild_shadow();
    sh_count   = 1;
    sh_off[0]  = '0;
    sh_len[0]  = (arena_reg > HDR) ? 16'(arena_reg - HDR) : 16'd0;
    sh_free[0] = 1'b1;
  endfunction

  function automatic void drop_entry(int idx);
    for (int k = idx; k + 1 < sh_count; k++) begin
      sh_off[k]  = sh_off[k + 1];
      sh_len[k]  = sh_len[k + 1];
      sh_free[k] = sh_free[k + 1];
    end
    sh_count--;
  endfunction

  function automatic rsp_t predict_alloc(logic [15:0] size);
    rsp_t r;
    int   i;
    int   best;
    bit   found;
    r = '0;
    i = 0;
    // Coalesce runs of free neighbors first
    while (i + 1 < sh_count) begin
      if (sh_free[i] && sh_free[i + 1]) begin
        sh_len[i] = 16'(sh_len[i] + sh_len[i + 1] + HDR);
        drop_entry(i + 1);
      end else begin
        i++;
      end
    end
    best  = 0;
    found = 1'b0;
    for (i = 0; i < sh_count; i++) begin
      if (sh_free[i] && sh_len[i] >= size && (!found || sh_len[i] < sh_len[best])) begin
        best  = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      r.status = ST_NO_FIT;
      return r;
    end
    if (sh_len[best] == size) begin
      sh_free[best] = 1'b0;
    end else if (32'(sh_len[best]) > 32'(size) + HDR) begin
      if (sh_count >= MAX_SEGS) begin
        r.status = ST_FULL;
        return r;
      end
      for (int k = sh_count; k > best + 1; k--) begin
        sh_off[k]  = sh_off[k - 1];
        sh_len[k]  = sh_len[k - 1];
        sh_free[k] = sh_free[k - 1];
      end
      sh_off[best + 1]  = 16'(sh_off[best] + HDR + size);
      sh_len[best + 1]  = 16'(sh_len[best] - size - HDR);
      sh_free[best + 1] = 1'b1;
      sh_len[best]      = size;
      sh_free[best]     = 1'b0;
      sh_count++;
    end else begin
      r.status = ST_NO_FIT;
      return r;
    end
    r.status       = ST_OK;
    r.payload_addr = 16'(sh_off[best] + HDR);
    return r;
  endfunction

  function automatic rsp_t predict_request(req_t req);
    rsp_t r;
    r = '0;
    case (req.req_type)
      REQ_ALLOC: r = predict_alloc(req.req_size);
      REQ_FREE: begin
        r.status = ST_BAD_ADDR;
        for (int i = 0; i < sh_count; i++) begin
          if (16'(sh_off[i] + HDR) == req.req_addr) begin
            sh_free[i] = 1'b1;
            r.status   = ST_OK;
            break;
          end
        end
      end
      REQ_INIT: rebuild_shadow();
      default: ;
    endcase
    return r;
  endfunction

  // Send one request beat; predict at acceptance
  task automatic send_request(req_code_t kind, logic [15:0] size, logic [15:0] addr);
    do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    in_valid         <= 1'b1;
    in_req.req_type  <= kind;
    in_req.req_size  <= size;
    in_req.req_addr  <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rsp_pending.push_back(predict_request('{kind, size, addr}));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_responses();
    while (rsp_pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  // Write arena_bytes while idle
  task automatic write_arena(logic [15:0] value);
    drain_responses();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    arena_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Pick a payload address: mostly a live segment, sometimes anything
  function automatic logic [15:0] pick_addr();
    if ($urandom_range(9) < 8) return 16'(sh_off[$urandom_range(sh_count - 1)] + HDR);
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_size();
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1:       return sh_len[$urandom_range(sh_count - 1)];
      2:       return 16'(sh_len[$urandom_range(sh_count - 1)] - $urandom_range(HDR));
      default: return 16'($urandom_range(300));
    endcase
  endfunction

  task automatic test_directed();
    send_request(REQ_ALLOC, 16'd0, 16'd0);
    send_request(REQ_ALLOC, 16'd100, 16'd0);
    send_request(REQ_ALLOC, 16'hFFFF, 16'hFFFF);
    send_request(REQ_FREE, 16'hFFFF, 16'd24);
    send_request(REQ_FREE, 16'd0, 16'd24);
    send_request(REQ_FREE, 16'd0, 16'd5);
    send_request(REQ_FREE, 16'd0, 16'hFFFF);
    send_request(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
    send_request(REQ_ALLOC, 16'd130, 16'd0);
    // Small allocation, split from the large free tail segment
    send_request(REQ_ALLOC, 16'd40, 16'd0);
    send_request(REQ_FREE, 16'd0, pick_addr());
    send_request(REQ_ALLOC, 16'd30, 16'd0);
    send_request(REQ_INIT, 16'hFFFF, 16'hFFFF);
    // Fill the table to its limit, then try an exact fit and a split
    for (int i = 0; i < MAX_SEGS; i++) send_request(REQ_ALLOC, 16'd8, 16'd0);
    send_request(REQ_FREE, 16'd0, 16'd24 + 16'd32);
    send_request(REQ_ALLOC, 16'd8, 16'd0);
    send_request(REQ_ALLOC, 16'd1, 16'd0);
    send_request(REQ_INIT, 16'd0, 16'd0);
  endtask

  task automatic test_tiny_arena();
    write_arena(16'd20);
    send_request(REQ_INIT, 16'd0, 16'd0);
    send_request(REQ_ALLOC, 16'd0, 16'd0);
    send_request(REQ_FREE, 16'd0, 16'd24);
    send_request(REQ_ALLOC, 16'd0, 16'd0);
    write_arena(16'd64);
    send_request(REQ_INIT, 16'd0, 16'd0);
    send_request(REQ_ALLOC, 16'd40, 16'd0);
  endtask

  task automatic test_random(int n, int idle, int stall);
    int roll;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 50)      send_request(REQ_ALLOC, pick_size(), 16'($urandom));
      else if (roll < 92) send_request(REQ_FREE, 16'($urandom), pick_addr());
      else if (roll < 96) send_request(REQ_INIT, 16'($urandom), 16'($urandom));
      else                send_request(REQ_UNUSED, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    err_count      = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    arena_reg = 16'd8192;
    rebuild_shadow();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_tiny_arena();
    write_arena(16'd65535);
    send_request(REQ_INIT, 16'd0, 16'd0);
    test_random(215, 0, 0);
    write_arena(16'd2000);
    send_request(REQ_INIT, 16'd0, 16'd0);
    test_random(215, 85, 0);
    write_arena(16'(16'd64 + $urandom_range(1500)));
    send_request(REQ_INIT, 16'd0, 16'd0);
    test_random(215, 0, 85);
    write_arena(16'd8192);
    send_request(REQ_INIT, 16'd0, 16'd0);
    test_random(215, 14, 14);

    drain_responses();
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
